[hdl/assert_macros.svh]
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge outside reset
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition that must never be seen outside reset
`define ASSERT_NEVER(lbl, cond, msg) \
  `ASSERT_CLK(lbl, !(cond), msg)

`endif

[hdl/md5_pkg.sv]
`timescale 1ns / 1ps

package md5_pkg;

  localparam int BLOCK_WORDS      = 16;
  localparam int QUEUE_DEPTH_DEF  = 2;

  localparam logic [31:0] MD5_INIT_A = 32'h67452301;
  localparam logic [31:0] MD5_INIT_B = 32'hefcdab89;
  localparam logic [31:0] MD5_INIT_C = 32'h98badcfe;
  localparam logic [31:0] MD5_INIT_D = 32'h10325476;

  localparam logic [7:0]  PAD_MARK   = 8'h80;

  // one 512-bit block handed from the packer to the round engine
  typedef struct packed {
    logic [BLOCK_WORDS-1:0][31:0] words;
    logic                         last;   // final block of a message
  } blk_item_t;

  function automatic logic [31:0] md5_sine(input logic [5:0] i);
    logic [31:0] k;
    case (i)
      6'd0:  k = 32'hd76aa478;  6'd1:  k = 32'he8c7b756;
      6'd2:  k = 32'h242070db;  6'd3:  k = 32'hc1bdceee;
      6'd4:  k = 32'hf57c0faf;  6'd5:  k = 32'h4787c62a;
      6'd6:  k = 32'ha8304613;  6'd7:  k = 32'hfd469501;
      6'd8:  k = 32'h698098d8;  6'd9:  k = 32'h8b44f7af;
      6'd10: k = 32'hffff5bb1;  6'd11: k = 32'h895cd7be;
      6'd12: k = 32'h6b901122;  6'd13: k = 32'hfd987193;
      6'd14: k = 32'ha679438e;  6'd15: k = 32'h49b40821;
      6'd16: k = 32'hf61e2562;  6'd17: k = 32'hc040b340;
      6'd18: k = 32'h265e5a51;  6'd19: k = 32'he9b6c7aa;
      6'd20: k = 32'hd62f105d;  6'd21: k = 32'h02441453;
      6'd22: k = 32'hd8a1e681;  6'd23: k = 32'he7d3fbc8;
      6'd24: k = 32'h21e1cde6;  6'd25: k = 32'hc33707d6;
      6'd26: k = 32'hf4d50d87;  6'd27: k = 32'h455a14ed;
      6'd28: k = 32'ha9e3e905;  6'd29: k = 32'hfcefa3f8;
      6'd30: k = 32'h676f02d9;  6'd31: k = 32'h8d2a4c8a;
      6'd32: k = 32'hfffa3942;  6'd33: k = 32'h8771f681;
      6'd34: k = 32'h6d9d6122;  6'd35: k = 32'hfde5380c;
      6'd36: k = 32'ha4beea44;  6'd37: k = 32'h4bdecfa9;
      6'd38: k = 32'hf6bb4b60;  6'd39: k = 32'hbebfbc70;
      6'd40: k = 32'h289b7ec6;  6'd41: k = 32'heaa127fa;
      6'd42: k = 32'hd4ef3085;  6'd43: k = 32'h04881d05;
      6'd44: k = 32'hd9d4d039;  6'd45: k = 32'he6db99e5;
      6'd46: k = 32'h1fa27cf8;  6'd47: k = 32'hc4ac5665;
      6'd48: k = 32'hf4292244;  6'd49: k = 32'h432aff97;
      6'd50: k = 32'hab9423a7;  6'd51: k = 32'hfc93a039;
      6'd52: k = 32'h655b59c3;  6'd53: k = 32'h8f0ccc92;
      6'd54: k = 32'hffeff47d;  6'd55: k = 32'h85845dd1;
      6'd56: k = 32'h6fa87e4f;  6'd57: k = 32'hfe2ce6e0;
      6'd58: k = 32'ha3014314;  6'd59: k = 32'h4e0811a1;
      6'd60: k = 32'hf7537e82;  6'd61: k = 32'hbd3af235;
      6'd62: k = 32'h2ad7d2bb;  6'd63: k = 32'heb86d391;
      default: k = '0;
    endcase
    return k;
  endfunction

  function automatic logic [4:0] md5_shift(input logic [5:0] i);
    logic [4:0] s;
    case ({i[5:4], i[1:0]})
      4'd0:  s = 5'd7;   4'd1:  s = 5'd12;  4'd2:  s = 5'd17;  4'd3:  s = 5'd22;
      4'd4:  s = 5'd5;   4'd5:  s = 5'd9;   4'd6:  s = 5'd14;  4'd7:  s = 5'd20;
      4'd8:  s = 5'd4;   4'd9:  s = 5'd11;  4'd10: s = 5'd16;  4'd11: s = 5'd23;
      4'd12: s = 5'd6;   4'd13: s = 5'd10;  4'd14: s = 5'd15;  4'd15: s = 5'd21;
      default: s = '0;
    endcase
    return s;
  endfunction

  // message word used by round i
  function automatic logic [3:0] md5_msg_index(input logic [5:0] i);
    logic [3:0] t;
    logic [3:0] g;
    t = i[3:0];
    case (i[5:4])
      2'd0:    g = t;
      2'd1:    g = 4'(t * 4'd5 + 4'd1);
      2'd2:    g = 4'(t * 4'd3 + 4'd5);
      default: g = 4'(t * 4'd7);
    endcase
    return g;
  endfunction

endpackage

[hdl/md5_byte_stream_hasher.sv]
`timescale 1ns / 1ps

// md5 digest of a byte stream
//
// input words: in_tdata[7:0] is one message byte, in_tuser says the byte
// belongs to the message, in_tlast closes the message. an end word with
// in_tuser low closes it without a byte, so an empty message hashes too.
// a word with both flags low is taken and dropped.
// output words: one 128-bit digest per message on out_tdata, digest byte 0
// in bits 7:0 through byte 15 in bits 127:120.
// the packer collects 64 bytes per block and pushes it, plus the one or two
// padding blocks at the end, into a small block queue. the round engine
// runs one md5 round per cycle: each block is loaded, goes through 64 rounds
// and ends with the chain add, and while digests are taken that engine sets
// the sustained rate of roughly one byte per cycle. the packer takes no byte
// while it pushes a full block. after the end word the digest waits for the
// padding block, or both blocks when the padding spills into a second block
// or the end word fills a block, and for each block still queued or in the rounds.
// reset (rst_n low, synchronous) empties the queue, clears the byte count
// and loads the standard chaining words; no clearing pass is needed.
// when out_tready is low the digest waits in the output register; the
// engine keeps working on blocks and stalls only at the next final block.
module md5_byte_stream_hasher
  import md5_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [7:0]   in_tdata,   // data_byte
  input  logic         in_tuser,   // byte_present
  input  logic         in_tlast,   // message_end
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [127:0] out_tdata   // digest_low [63:0], digest_high [127:64]
);

  // packer to queue
  logic      push;
  blk_item_t push_item;
  logic      push_ready;
  // queue to round engine
  logic      pop_valid;
  blk_item_t pop_item;
  logic      pop;

  md5_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .in_tuser     (in_tuser),
    .in_tlast     (in_tlast),
    .push_o       (push),
    .push_item_o  (push_item),
    .push_ready_i (push_ready)
  );

  md5_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk          (clk),
    .rst_n        (rst_n),
    .push_i       (push),
    .push_item_i  (push_item),
    .push_ready_o (push_ready),
    .pop_valid_o  (pop_valid),
    .pop_item_o   (pop_item),
    .pop_i        (pop)
  );

  // round engine: one round per cycle, chain add, digest register
  md5_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .pop_valid_i (pop_valid),
    .pop_item_i  (pop_item),
    .pop_o       (pop),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata)
  );

endmodule

[hdl/md5_front.sv]
`timescale 1ns / 1ps

module md5_front
  import md5_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,
  input  logic        in_tuser,
  input  logic        in_tlast,
  output logic        push_o,
  output blk_item_t   push_item_o,
  input  logic        push_ready_i
);

  typedef enum logic [3:0] {
    F_COLLECT = 4'b0001,
    F_FULL    = 4'b0010,
    F_PAD     = 4'b0100,
    F_PAD2    = 4'b1000
  } front_state_t;

  front_state_t                  state_r, state_nxt;
  logic [60:0]                   cnt_r, cnt_nxt;
  logic                          end_pend_r, end_pend_nxt;
  logic [BLOCK_WORDS-1:0][31:0]  blk_r;
  logic [5:0]                    pos;
  logic [63:0]                   bit_len;
  logic                          accept;

  // bytes below pos kept, optional mark at pos, zero fill, optional length in words 14 and 15
  function automatic logic [BLOCK_WORDS-1:0][31:0] pad_block(
    input logic [BLOCK_WORDS-1:0][31:0] blk,
    input logic [5:0]                   fill,
    input logic                         mark,
    input logic                         with_len,
    input logic [63:0]                  len
  );
    logic [BLOCK_WORDS-1:0][31:0] res;
    res = '0;
    for (int p = 0; p < 64; p++) begin
      if (6'(p) < fill) begin
        res[p / 4][(p % 4) * 8 +: 8] = blk[p / 4][(p % 4) * 8 +: 8];
      end else if (mark && (6'(p) == fill)) begin
        res[p / 4][(p % 4) * 8 +: 8] = PAD_MARK;
      end
    end
    if (with_len) begin
      res[14] = len[31:0];
      res[15] = len[63:32];
    end
    return res;
  endfunction

  assign pos       = cnt_r[5:0];
  assign bit_len   = {cnt_r, 3'b000};
  assign in_tready = (state_r == F_COLLECT);
  assign accept    = in_tvalid && in_tready;

  always_comb begin
    state_nxt   = state_r;
    cnt_nxt     = cnt_r;
    end_pend_nxt = end_pend_r;
    push_o      = 1'b0;
    push_item_o = '{words: blk_r, last: 1'b0};
    case (state_r)
      F_COLLECT: begin
        if (accept) begin
          if (in_tuser) begin
            cnt_nxt = cnt_r + 61'd1;
          end
          if (in_tuser && (pos == 6'd63)) begin
            state_nxt    = F_FULL;
            end_pend_nxt = in_tlast;
          end else if (in_tlast) begin
            state_nxt = F_PAD;
          end
        end
      end
      F_FULL: begin
        push_o = 1'b1;
        if (push_ready_i) begin
          state_nxt = end_pend_r ? F_PAD : F_COLLECT;
        end
      end
      F_PAD: begin
        push_o = 1'b1;
        if (pos < 6'd56) begin
          push_item_o = '{words: pad_block(blk_r, pos, 1'b1, 1'b1, bit_len), last: 1'b1};
          if (push_ready_i) begin
            state_nxt = F_COLLECT;
            cnt_nxt   = '0;
          end
        end else begin
          // mark fits but the length does not: spill into a second block
          push_item_o = '{words: pad_block(blk_r, pos, 1'b1, 1'b0, bit_len), last: 1'b0};
          if (push_ready_i) begin
            state_nxt = F_PAD2;
          end
        end
      end
      F_PAD2: begin
        push_o      = 1'b1;
        push_item_o = '{words: pad_block(blk_r, 6'd0, 1'b0, 1'b1, bit_len), last: 1'b1};
        if (push_ready_i) begin
          state_nxt = F_COLLECT;
          cnt_nxt   = '0;
        end
      end
      default: begin
        state_nxt = F_COLLECT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= F_COLLECT;
      cnt_r      <= '0;
      end_pend_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      cnt_r      <= cnt_nxt;
      end_pend_r <= end_pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && in_tuser) begin
      blk_r[pos[5:2]][{pos[1:0], 3'b000} +: 8] <= in_tdata;
    end
  end

endmodule

[hdl/md5_queue.sv]
`timescale 1ns / 1ps

module md5_queue
  import md5_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push_i,
  input  blk_item_t push_item_i,
  output logic      push_ready_o,
  output logic      pop_valid_o,
  output blk_item_t pop_item_o,
  input  logic      pop_i
);

  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  blk_item_t       mem_r [DEPTH];
  logic [IW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]   count_r;
  logic            do_push, do_pop;

  assign push_ready_o = (count_r != CW'(DEPTH));
  assign pop_valid_o  = (count_r != '0);
  assign do_push      = push_i && push_ready_o;
  assign do_pop       = pop_i && pop_valid_o;
  assign pop_item_o   = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_item_i;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == IW'(DEPTH - 1)) ? '0 : wr_ptr_r + IW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == IW'(DEPTH - 1)) ? '0 : rd_ptr_r + IW'(1);
      end
      case ({do_push, do_pop})
        2'b10:   count_r <= count_r + CW'(1);
        2'b01:   count_r <= count_r - CW'(1);
        default: count_r <= count_r;
      endcase
    end
  end

`include "assert_macros.svh"

  `ASSERT_NEVER(a_q_pop_empty, pop_i && !pop_valid_o, "queue popped while empty")
  `ASSERT_CLK(a_q_count_bound, count_r <= CW'(DEPTH), "queue count beyond depth")

endmodule

[hdl/md5_core.sv]
`timescale 1ns / 1ps

module md5_core
  import md5_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         pop_valid_i,
  input  blk_item_t    pop_item_i,
  output logic         pop_o,
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [127:0] out_tdata
);

  typedef enum logic [2:0] {
    C_IDLE  = 3'b001,
    C_ROUND = 3'b010,
    C_ADD   = 3'b100
  } core_state_t;

  core_state_t                   state_r, state_nxt;
  logic [5:0]                    rnd_r;
  logic                          last_r;
  logic [BLOCK_WORDS-1:0][31:0]  msg_r;
  logic [31:0]                   a_r, b_r, c_r, d_r;
  logic [31:0]                   chain_r [4];
  logic                          out_valid_r, out_valid_nxt;
  logic [127:0]                  out_data_r;
  logic [31:0]                   f_val, sum, rot;
  logic [63:0]                   rot_wide;
  logic [31:0]                   sa, sb, sc, sd;
  logic                          out_free;
  logic                          finish;

  // round function by quarter
  always_comb begin
    case (rnd_r[5:4])
      2'd0:    f_val = (b_r & c_r) | (~b_r & d_r);
      2'd1:    f_val = (d_r & b_r) | (~d_r & c_r);
      2'd2:    f_val = b_r ^ c_r ^ d_r;
      default: f_val = c_r ^ (b_r | ~d_r);
    endcase
  end

  assign sum      = a_r + f_val + md5_sine(rnd_r) + msg_r[md5_msg_index(rnd_r)];
  assign rot_wide = {sum, sum} << md5_shift(rnd_r);
  assign rot      = rot_wide[63:32];

  assign sa = chain_r[0] + a_r;
  assign sb = chain_r[1] + b_r;
  assign sc = chain_r[2] + c_r;
  assign sd = chain_r[3] + d_r;

  assign out_free   = !out_valid_r || out_tready;
  assign pop_o      = (state_r == C_IDLE) && pop_valid_i;
  assign finish     = (state_r == C_ADD) && (!last_r || out_free);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_tready;
    case (state_r)
      C_IDLE: begin
        if (pop_valid_i) begin
          state_nxt = C_ROUND;
        end
      end
      C_ROUND: begin
        if (rnd_r == 6'd63) begin
          state_nxt = C_ADD;
        end
      end
      C_ADD: begin
        if (finish) begin
          state_nxt = C_IDLE;
          if (last_r) begin
            out_valid_nxt = 1'b1;
          end
        end
      end
      default: begin
        state_nxt = C_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= C_IDLE;
      rnd_r       <= '0;
      out_valid_r <= 1'b0;
      chain_r[0]  <= MD5_INIT_A;
      chain_r[1]  <= MD5_INIT_B;
      chain_r[2]  <= MD5_INIT_C;
      chain_r[3]  <= MD5_INIT_D;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (state_r == C_ROUND) begin
        rnd_r <= rnd_r + 6'd1;
      end
      if (finish) begin
        if (last_r) begin
          // message done: chaining words back to their start values
          chain_r[0] <= MD5_INIT_A;
          chain_r[1] <= MD5_INIT_B;
          chain_r[2] <= MD5_INIT_C;
          chain_r[3] <= MD5_INIT_D;
        end else begin
          chain_r[0] <= sa;
          chain_r[1] <= sb;
          chain_r[2] <= sc;
          chain_r[3] <= sd;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop_o) begin
      msg_r  <= pop_item_i.words;
      last_r <= pop_item_i.last;
      a_r    <= chain_r[0];
      b_r    <= chain_r[1];
      c_r    <= chain_r[2];
      d_r    <= chain_r[3];
    end else if (state_r == C_ROUND) begin
      a_r <= d_r;
      b_r <= b_r + rot;
      c_r <= b_r;
      d_r <= c_r;
    end
    if (finish && last_r) begin
      out_data_r <= {sd, sc, sb, sa};
    end
  end

`include "assert_macros.svh"

  `ASSERT_CLK(a_core_round_end, (state_r == C_ROUND) && (rnd_r == 6'd63) |=> (state_r == C_ADD),
              "round loop did not end after the last round")
  `ASSERT_CLK(a_core_idle_rnd, (state_r == C_IDLE) |-> (rnd_r == 6'd0),
              "round counter not parked between blocks")

endmodule

[tb/md5_byte_stream_hasher_tb.sv]
`timescale 1ns / 1ps

module md5_byte_stream_hasher_tb
  import md5_pkg::*;
();

  // run shape
  localparam int WORD_TARGET    = 1950;   // words to send over the whole run
  localparam int GAP_MAX        = 19;     // longest per-word idle of either side
  localparam int HOLD_AT_DIGEST = 15;     // sink stops taking digests after this many
  localparam int HOLD_CYCLES    = 2000;   // length of that stop
  localparam int DRAIN_AT_MSG   = 20;     // source pauses for a full drain after this message
  localparam int TAIL_CYCLES    = 300;    // above the two-block digest latency
  localparam int STALL_LIMIT    = 20000;  // cycles with no word moving on either side

  // md5 sine constants, round 0 first
  localparam logic [0:63][31:0] MD5_K = {
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
    32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
    32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
    32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
    32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
    32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
    32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
    32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
    32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
    32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
    32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
  };

  // left-rotate amounts, indexed by {round group, round mod 4}
  localparam logic [0:15][4:0] ROT_AMT = {
    5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
    5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
  };

  // message lengths around the padding boundaries (one or two tail blocks)
  localparam logic [0:10][8:0] EDGE_LENS = {
    9'd55, 9'd56, 9'd57, 9'd63, 9'd64, 9'd65, 9'd119, 9'd120, 9'd121, 9'd127, 9'd128
  };

  // digest as it sits on out_tdata: bytes 8..15 above bytes 0..7
  typedef struct packed {
    logic [63:0] digest_high;
    logic [63:0] digest_low;
  } digest_t;

  // well-known digests, byte 0 of the hex string in the lowest bits
  localparam digest_t EMPTY_DIGEST = {64'h7e42f8ec980980e9, 64'h04b2008fd98c1dd4};
  localparam digest_t A_DIGEST     = {64'h61267769e299c331, 64'ha8b6f1c0b975c10c};

  typedef struct packed {
    logic [7:0] data;
    logic       present;
    logic       last;
    logic       typed;    // digest below is the known answer
    digest_t    digest;
  } stim_row_t;

  // directed words: empty message, dropped words, one-byte messages, end with and
  // without a byte, byte extremes
  localparam stim_row_t [0:11] DIRECTED_ROWS = {
    {8'h00, 1'b0, 1'b1, 1'b1, EMPTY_DIGEST},  // empty message after reset
    {8'hff, 1'b0, 1'b0, 1'b0, 128'd0},        // no byte, no end: dropped
    {8'h61, 1'b1, 1'b1, 1'b1, A_DIGEST},      // "a", byte rides on the end word
    {8'h00, 1'b1, 1'b0, 1'b0, 128'd0},
    {8'hff, 1'b0, 1'b0, 1'b0, 128'd0},        // dropped word inside a message
    {8'hff, 1'b1, 1'b0, 1'b0, 128'd0},
    {8'h5a, 1'b1, 1'b0, 1'b0, 128'd0},
    {8'ha5, 1'b1, 1'b0, 1'b0, 128'd0},
    {8'h00, 1'b0, 1'b1, 1'b0, 128'd0},        // end without a byte
    {8'hff, 1'b0, 1'b1, 1'b1, EMPTY_DIGEST},  // empty again, data must be ignored
    {8'h80, 1'b1, 1'b1, 1'b0, 128'd0},
    {8'hff, 1'b1, 1'b1, 1'b0, 128'd0}
  };

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [7:0]   in_tdata;   // data_byte
  logic         in_tuser;   // byte_present
  logic         in_tlast;   // message_end
  logic         out_tvalid;
  logic         out_tready;
  logic [127:0] out_tdata;  // digest_low [63:0], digest_high [127:64]

  // predictor state
  logic [31:0] hash_chain [4];
  logic [31:0] msg_block [16];
  logic [60:0] msg_bytes;

  digest_t pending_digests [$];
  digest_t got_digest;
  digest_t want_digest;
  int      error_count;
  int      words_sent;
  int      digests_expected;
  int      digests_seen;
  int      stall_cycles;
  bit      fast_send;
  bit      hold_active;

  md5_byte_stream_hasher u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------- predictor

  function automatic void clear_hash();
    hash_chain[0] = MD5_INIT_A;
    hash_chain[1] = MD5_INIT_B;
    hash_chain[2] = MD5_INIT_C;
    hash_chain[3] = MD5_INIT_D;
    msg_bytes = '0;
  endfunction

  // 64 rounds over msg_block, added into the chain
  function automatic void run_rounds();
    logic [31:0] a, b, c, d, f, t;
    int          g;
    int          s;
    a = hash_chain[0];
    b = hash_chain[1];
    c = hash_chain[2];
    d = hash_chain[3];
    for (int i = 0; i < 64; i++) begin
      case (i / 16)
        0: begin
          f = (b & c) | (~b & d);
          g = i;
        end
        1: begin
          f = (d & b) | (~d & c);
          g = (5 * i + 1) % 16;
        end
        2: begin
          f = b ^ c ^ d;
          g = (3 * i + 5) % 16;
        end
        default: begin
          f = c ^ (b | ~d);
          g = (7 * i) % 16;
        end
      endcase
      t = f + a + MD5_K[i] + msg_block[g];
      s = int'(ROT_AMT[(i / 16) * 4 + i % 4]);
      a = d;
      d = c;
      c = b;
      b = b + ((t << s) | (t >> (32 - s)));
    end
    hash_chain[0] = hash_chain[0] + a;
    hash_chain[1] = hash_chain[1] + b;
    hash_chain[2] = hash_chain[2] + c;
    hash_chain[3] = hash_chain[3] + d;
  endfunction

  // little-endian byte lane; first byte of a word clears the rest
  function automatic void put_msg_byte(input int pos, input logic [7:0] b);
    if (pos % 4 == 0) begin
      msg_block[pos / 4] = {24'd0, b};
    end else begin
      msg_block[pos / 4] = msg_block[pos / 4] | ({24'd0, b} << (8 * (pos % 4)));
    end
  endfunction

  // takes one accepted word, returns 1 with the digest when a message closes
  function automatic bit hash_word(input logic [7:0] data, input logic present,
                                   input logic last, output digest_t digest);
    int          pos;
    logic [63:0] bit_len;
    digest = '0;
    if (present) begin
      put_msg_byte(int'(msg_bytes[5:0]), data);
      msg_bytes = msg_bytes + 61'd1;
      if (msg_bytes[5:0] == 6'd0) run_rounds();
    end
    if (!last) return 1'b0;
    pos = int'(msg_bytes[5:0]);
    put_msg_byte(pos, PAD_MARK);
    pos++;
    // no room for the length: close this block and pad a fresh one
    if (pos > 56) begin
      while (pos < 64) begin
        put_msg_byte(pos, 8'h00);
        pos++;
      end
      run_rounds();
      pos = 0;
    end
    while (pos < 56) begin
      put_msg_byte(pos, 8'h00);
      pos++;
    end
    bit_len = {msg_bytes, 3'b000};
    msg_block[14] = bit_len[31:0];
    msg_block[15] = bit_len[63:32];
    run_rounds();
    digest.digest_low  = {hash_chain[1], hash_chain[0]};
    digest.digest_high = {hash_chain[3], hash_chain[2]};
    clear_hash();
    return 1'b1;
  endfunction

  // appends one expected digest behind the ones already waiting
  function automatic void queue_expected(input digest_t d);
    pending_digests.insert(pending_digests.size(), d);
    digests_expected++;
  endfunction

  // ---------------------------------------------------------------- checking

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch: %s got %h want %h at %0t", what, got, want, $time);
    error_count++;
  endtask

  // digests are sampled at the rising edge, before the block updates
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      digests_seen++;
      got_digest = out_tdata;
      if (pending_digests.size() == 0) begin
        report_mismatch("digest_low with nothing pending", got_digest.digest_low, '0);
      end else begin
        want_digest = pending_digests.pop_front();
        if (got_digest.digest_low !== want_digest.digest_low)
          report_mismatch("digest_low", got_digest.digest_low, want_digest.digest_low);
        if (got_digest.digest_high !== want_digest.digest_high)
          report_mismatch("digest_high", got_digest.digest_high, want_digest.digest_high);
      end
    end
  end

  // run ends here when nothing moves for too long
  initial begin : watchdog
    stall_cycles = 0;
    while (stall_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) stall_cycles = 0;
      else stall_cycles++;
    end
    $display("md5_byte_stream_hasher_tb: done, errors");
    $finish;
  end

  // ---------------------------------------------------------------- digest sink

  // random readiness per digest, runs with no stall, and one long hold-off that
  // backs the block up into its input
  initial begin : digest_sink
    int gap;
    bit fast_take;
    bit hold_done;
    out_tready  = 1'b0;
    hold_active = 1'b0;
    fast_take   = 1'b0;
    hold_done   = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    @(negedge clk);
    forever begin
      if ($urandom_range(0, 7) == 0) fast_take = !fast_take;
      gap = fast_take ? 0 : $urandom_range(0, GAP_MAX);
      if (digests_seen >= HOLD_AT_DIGEST && !hold_done) begin
        gap         = HOLD_CYCLES;
        hold_active = 1'b1;
        hold_done   = 1'b1;
      end
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      hold_active = 1'b0;
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
      @(negedge clk);
    end
  end

  // ---------------------------------------------------------------- byte source

  // offers one word after a random gap, predicts it once it is taken
  task automatic send_word(input logic [7:0] data, input logic present, input logic last,
                           input logic typed, input digest_t typed_digest);
    digest_t predicted;
    int      gap;
    gap = (fast_send || hold_active) ? 0 : $urandom_range(0, GAP_MAX);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= data;
    in_tuser  <= present;
    in_tlast  <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (hash_word(data, present, last, predicted)) begin
      queue_expected(typed ? typed_digest : predicted);
    end
    words_sent++;
    @(negedge clk);
  endtask

  // source holds off until every predicted digest is out
  task automatic wait_for_digests();
    in_tvalid <= 1'b0;
    while (pending_digests.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  initial begin : byte_source
    int len;
    int pick;
    int msg_count;
    bit end_with_byte;
    rst_n            = 1'b0;
    in_tvalid        = 1'b0;
    in_tdata         = '0;
    in_tuser         = 1'b0;
    in_tlast         = 1'b0;
    fast_send        = 1'b0;
    error_count      = 0;
    words_sent       = 0;
    digests_expected = 0;
    digests_seen     = 0;
    msg_count        = 0;
    clear_hash();
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed part
    for (int r = 0; r < 12; r++) begin
      send_word(DIRECTED_ROWS[r].data, DIRECTED_ROWS[r].present, DIRECTED_ROWS[r].last,
                DIRECTED_ROWS[r].typed, DIRECTED_ROWS[r].digest);
    end
    wait_for_digests();

    // random messages: mostly short, many on the padding edges, a few long
    while (words_sent < WORD_TARGET) begin
      fast_send = ($urandom_range(0, 3) == 0);
      pick = $urandom_range(0, 99);
      if (pick < 45) len = $urandom_range(0, 10);
      else if (pick < 75) len = int'(EDGE_LENS[$urandom_range(0, 10)]);
      else if (pick < 95) len = $urandom_range(11, 70);
      else len = $urandom_range(71, 300);
      end_with_byte = (len > 0) && ($urandom_range(0, 1) == 1);
      for (int k = 0; k < len; k++) begin
        // now and then a dropped word between bytes
        if ($urandom_range(0, 15) == 0)
          send_word(8'($urandom_range(0, 255)), 1'b0, 1'b0, 1'b0, '0);
        send_word(8'($urandom_range(0, 255)), 1'b1, end_with_byte && (k == len - 1),
                  1'b0, '0);
      end
      if (!end_with_byte) send_word(8'($urandom_range(0, 255)), 1'b0, 1'b1, 1'b0, '0);
      msg_count++;
      if (msg_count == DRAIN_AT_MSG) wait_for_digests();
    end

    // drain, then leave room for anything stray
    in_tvalid <= 1'b0;
    while (pending_digests.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("md5_byte_stream_hasher_tb: done, clean");
    end else begin
      $display("md5_byte_stream_hasher_tb: done, errors");
    end
    $finish;
  end

endmodule
